>>> sv/lrucd_pkg.sv
// Shared widths, codes and chain structs of the LRU object cache directory.
`default_nettype none
package lrucd_pkg;

  localparam int ENTRIES_DEF  = 10;
  localparam int KEY_BITS_DEF = 64;

  localparam int KEY_W      = 64;
  localparam int OBJ_SIZE_W = 24;
  localparam int SIZE_W     = 20;
  localparam int SLOT_W     = 4;
  localparam int RANK_W     = 4;

  localparam logic [SIZE_W-1:0] MAX_OBJ_RESET = 20'd102400;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // first valid match, rippled from cell to cell
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
    logic [RANK_W-1:0] rank;
    logic [SIZE_W-1:0] size;
  } lrucd_find_t;

  // slot holding the oldest rank, rippled from cell to cell
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } lrucd_vic_t;

  // update broadcast to every cell
  typedef struct packed {
    logic              hit_en;
    logic              ins_en;
    logic [SLOT_W-1:0] target;
    logic [RANK_W-1:0] hit_rank;
  } lrucd_upd_t;

endpackage
`default_nettype wire

>>> sv/lrucd_if.sv
// Valid/ready channel interfaces for request and result words.
`default_nettype none
interface lrucd_in_if;
  import lrucd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [KEY_W-1:0]      key;
  logic [OBJ_SIZE_W-1:0] object_size;

  modport source (output valid, output op, output key, output object_size, input ready);
  modport sink   (input valid, input op, input key, input object_size, output ready);
endinterface

interface lrucd_out_if;
  import lrucd_pkg::*;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic [SIZE_W-1:0] stored_size;
  logic              inserted;

  modport source (output valid, output hit, output slot, output stored_size,
                  output inserted, input ready);
  modport sink   (input valid, input hit, input slot, input stored_size,
                  input inserted, output ready);
endinterface
`default_nettype wire

>>> sv/lrucd_cell.sv
// One directory slot: key, size, valid bit and LRU rank, with chain hand-off.
`default_nettype none
module lrucd_cell #(
  parameter int IDX      = 0,
  parameter int ENTRIES  = lrucd_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lrucd_pkg::KEY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [KEY_BITS-1:0]            cmp_key,
  input  lrucd_pkg::lrucd_find_t         find_i,
  output lrucd_pkg::lrucd_find_t         find_o,
  input  lrucd_pkg::lrucd_vic_t          vic_i,
  output lrucd_pkg::lrucd_vic_t          vic_o,
  input  lrucd_pkg::lrucd_upd_t          upd_i,
  input  logic [KEY_BITS-1:0]            wr_key,
  input  logic [lrucd_pkg::SIZE_W-1:0]   wr_size
);
  import lrucd_pkg::*;

  logic [KEY_BITS-1:0] key_r;
  logic [SIZE_W-1:0]   size_r;
  logic                valid_r, valid_nxt;
  logic [RANK_W-1:0]   rank_r, rank_nxt;
  logic                is_target;

  assign is_target = (upd_i.target == SLOT_W'(IDX));

  // keep the first match from the left, else offer this slot
  always_comb begin
    find_o = find_i;
    if (!find_i.found && valid_r && (key_r == cmp_key)) begin
      find_o.found = 1'b1;
      find_o.idx   = SLOT_W'(IDX);
      find_o.rank  = rank_r;
      find_o.size  = size_r;
    end
  end

  always_comb begin
    vic_o = vic_i;
    if (!vic_i.found && (rank_r == RANK_W'(ENTRIES))) begin
      vic_o.found = 1'b1;
      vic_o.idx   = SLOT_W'(IDX);
    end
  end

  always_comb begin
    rank_nxt  = rank_r;
    valid_nxt = valid_r;
    if (upd_i.hit_en) begin
      // promote the hit slot, age those more recent than it
      if (is_target) begin
        rank_nxt = RANK_W'(1);
      end else if (rank_r < upd_i.hit_rank) begin
        rank_nxt = rank_r + RANK_W'(1);
      end
    end else if (upd_i.ins_en) begin
      if (is_target) begin
        rank_nxt  = RANK_W'(1);
        valid_nxt = 1'b1;
      end else begin
        rank_nxt = rank_r + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= RANK_W'(ENTRIES - IDX);
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_i.ins_en && is_target) begin
      key_r  <= wr_key;
      size_r <= wr_size;
    end
  end

endmodule
`default_nettype wire

>>> sv/lru_object_cache_directory_core.sv
// Top level of the LRU object cache directory: request handshake, cell chain, result register.
`default_nettype none
// Fully associative directory of ENTRIES slots with rank-counter LRU replacement.
// A request word is handled in order: at the accepting edge every cell compares
// the key and the match and oldest-slot searches ripple down the cell chain into a
// request register; at the commit edge, when the output register is free or read,
// the ranks, keys and sizes are updated and the result word is loaded into the output
// register. No new request is taken until the last one has committed; a result left
// waiting holds the second step of the following request. The size limit written
// through cfg_wr_en/cfg_wr_data resets to 102400 bytes and may only be changed while
// the block is idle. Empty slots never match; no clearing pass is needed after reset.
module lru_object_cache_directory_core #(
  parameter int ENTRIES  = lrucd_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lrucd_pkg::KEY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lrucd_in_if.sink                     in_ch,
  lrucd_out_if.source                  out_ch,
  input  logic                         cfg_wr_en,
  input  logic [lrucd_pkg::SIZE_W-1:0] cfg_wr_data
);
  import lrucd_pkg::*;

  logic                busy_r;
  logic                out_valid_r;
  logic [SIZE_W-1:0]   max_r;
  logic                accept, commit, fits;

  logic                s1_op_r;
  logic                s1_fits_r;
  logic [KEY_BITS-1:0] s1_key_r;
  logic [SIZE_W-1:0]   s1_size_r;
  lrucd_find_t         s1_find_r;
  lrucd_vic_t          s1_vic_r;

  logic                out_hit_r, out_ins_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [SIZE_W-1:0]   out_size_r;

  logic [KEY_BITS-1:0] cmp_key;
  lrucd_find_t         find_c [ENTRIES+1];
  lrucd_vic_t          vic_c  [ENTRIES+1];
  lrucd_upd_t          upd;

  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && !busy_r;
  assign commit      = busy_r && (!out_valid_r || out_ch.ready);
  assign cmp_key     = in_ch.key[KEY_BITS-1:0];
  assign fits        = (in_ch.object_size <= OBJ_SIZE_W'(max_r));

  assign find_c[0] = '0;
  assign vic_c[0]  = '0;

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      lrucd_cell #(
        .IDX      (gi),
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmp_key (cmp_key),
        .find_i  (find_c[gi]),
        .find_o  (find_c[gi+1]),
        .vic_i   (vic_c[gi]),
        .vic_o   (vic_c[gi+1]),
        .upd_i   (upd),
        .wr_key  (s1_key_r),
        .wr_size (s1_size_r)
      );
    end
  endgenerate

  always_comb begin
    upd.hit_en   = commit && (s1_op_r == OP_LOOKUP) && s1_find_r.found;
    upd.ins_en   = commit && (s1_op_r == OP_INSERT) && s1_fits_r;
    upd.target   = (s1_op_r == OP_LOOKUP) ? s1_find_r.idx : s1_vic_r.idx;
    upd.hit_rank = s1_find_r.rank;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      max_r       <= MAX_OBJ_RESET;
    end else begin
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
      if (accept) begin
        busy_r <= 1'b1;
      end else if (commit) begin
        busy_r <= 1'b0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the request and its search results until the update step
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r   <= in_ch.op;
      s1_fits_r <= fits;
      s1_key_r  <= cmp_key;
      s1_size_r <= in_ch.object_size[SIZE_W-1:0];
      s1_find_r <= find_c[ENTRIES];
      s1_vic_r  <= vic_c[ENTRIES];
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r  <= upd.hit_en;
      out_ins_r  <= upd.ins_en;
      out_slot_r <= (upd.hit_en || upd.ins_en) ? upd.target : '0;
      out_size_r <= upd.hit_en ? s1_find_r.size : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.slot        = out_slot_r;
  assign out_ch.stored_size = out_size_r;
  assign out_ch.inserted    = out_ins_r;

endmodule
`default_nettype wire

>>> test/tb_lru_object_cache_directory_core.sv
// Testbench for the LRU object cache directory: directed and random traffic checked against a rank-LRU predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_lru_object_cache_directory_core;
  import lrucd_pkg::*;

  localparam int NSLOTS     = ENTRIES_DEF;
  localparam int STALL_MAX  = 17;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic                  op;
    logic [KEY_W-1:0]      key;
    logic [OBJ_SIZE_W-1:0] size;
  } dir_req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] size;
    logic              inserted;
  } dir_rsp_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [SIZE_W-1:0] cfg_wr_data;

  lrucd_in_if  req_ch ();
  lrucd_out_if rsp_ch ();

  lru_object_cache_directory_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (req_ch),
    .out_ch      (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // directory shadow
  logic [KEY_W-1:0]  dir_key   [NSLOTS];
  logic [SIZE_W-1:0] dir_size  [NSLOTS];
  logic              dir_valid [NSLOTS];
  logic [RANK_W-1:0] dir_rank  [NSLOTS];
  logic [SIZE_W-1:0] size_limit;

  dir_req_t req_q [$];
  dir_rsp_t rsp_q [$];
  logic [KEY_W-1:0] recent_keys [$];

  int   errors;
  int   send_gap;
  int   stall_left;
  int   idle_cycles;
  int   n_hit, n_miss, n_stored, n_refused, n_cfg;
  logic calm;

  function automatic dir_rsp_t dir_access(dir_req_t r);
    dir_rsp_t rsp;
    logic [RANK_W-1:0] hit_rank;
    int victim;
    rsp = '0;
    if (r.op == OP_LOOKUP) begin
      for (int i = 0; i < NSLOTS; i++) begin
        if (!rsp.hit && dir_valid[i] && dir_key[i] == r.key) begin
          rsp.hit  = 1'b1;
          rsp.slot = SLOT_W'(i);
          rsp.size = dir_size[i];
        end
      end
      if (rsp.hit) begin
        // age every slot more recent than the hit one
        hit_rank = dir_rank[rsp.slot];
        for (int i = 0; i < NSLOTS; i++)
          if (dir_rank[i] < hit_rank) dir_rank[i] = dir_rank[i] + 1'b1;
        dir_rank[rsp.slot] = 1;
      end
    end else if (r.size <= {4'b0, size_limit}) begin
      victim = 0;
      for (int i = 1; i < NSLOTS; i++)
        if (dir_rank[i] > dir_rank[victim]) victim = i;
      dir_key[victim]   = r.key;
      dir_size[victim]  = r.size[SIZE_W-1:0];
      dir_valid[victim] = 1'b1;
      dir_rank[victim]  = 0;
      for (int i = 0; i < NSLOTS; i++) dir_rank[i] = dir_rank[i] + 1'b1;
      rsp.slot     = SLOT_W'(victim);
      rsp.inserted = 1'b1;
    end
    return rsp;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    dir_rsp_t exp_rsp;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        exp_rsp = dir_access(req_q.pop_front());
        rsp_q.push_back(exp_rsp);
        if (exp_rsp.hit) n_hit++;
        else if (exp_rsp.inserted) n_stored++;
        else if (req_ch.op == OP_LOOKUP) n_miss++;
        else n_refused++;
      end
      // hold the word until it is taken
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          req_ch.valid       <= 1'b1;
          req_ch.op          <= req_q[0].op;
          req_ch.key         <= req_q[0].key;
          req_ch.object_size <= req_q[0].size;
          if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, STALL_MAX);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    dir_rsp_t got, exp_rsp;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = {rsp_ch.hit, rsp_ch.slot, rsp_ch.stored_size, rsp_ch.inserted};
        if (rsp_q.size() == 0) begin
          $display("%0t: unexpected result word hit=%0b slot=%0d size=%0d inserted=%0b",
                   $time, got.hit, got.slot, got.size, got.inserted);
          errors++;
        end else begin
          exp_rsp = rsp_q.pop_front();
          if (got !== exp_rsp) begin
            $display("%0t: mismatch expected hit=%0b slot=%0d size=%0d inserted=%0b",
                     $time, exp_rsp.hit, exp_rsp.slot, exp_rsp.size, exp_rsp.inserted);
            $display("%0t:          actual   hit=%0b slot=%0d size=%0d inserted=%0b",
                     $time, got.hit, got.slot, got.size, got.inserted);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, STALL_MAX) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d requests queued, %0d results due",
               $time, IDLE_LIMIT, req_q.size(), rsp_q.size());
      $display("FAIL lru_object_cache_directory_core");
      $finish;
    end
  end

  task automatic put(logic op, logic [KEY_W-1:0] key, logic [OBJ_SIZE_W-1:0] size);
    dir_req_t r;
    r.op   = op;
    r.key  = key;
    r.size = size;
    req_q.push_back(r);
  endtask

  // well-formed traffic: lookups mostly aim at recently inserted keys
  task automatic gen_items(int n);
    dir_req_t r;
    int pick;
    for (int k = 0; k < n; k++) begin
      r.op   = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_LOOKUP;
      r.key  = {$urandom, $urandom};
      r.size = OBJ_SIZE_W'($urandom_range(0, 24'hFFFFFF));
      if (r.op == OP_INSERT) begin
        pick = $urandom_range(0, 19);
        if (pick < 13) r.size = OBJ_SIZE_W'($urandom_range(0, size_limit));
        else if (pick == 13) r.size = {4'b0, size_limit};
        else if (pick == 14) r.size = {4'b0, size_limit} + 1'b1;
        if (recent_keys.size() > 0 && $urandom_range(0, 9) == 0)
          r.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        recent_keys.push_back(r.key);
        if (recent_keys.size() > 14) void'(recent_keys.pop_front());
      end else if (recent_keys.size() > 0 && $urandom_range(0, 9) < 7) begin
        r.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      end
      req_q.push_back(r);
    end
  endtask

  task automatic drain();
    while (req_q.size() != 0 || rsp_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(logic [SIZE_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    size_limit = value;
    n_cfg++;
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    req_ch.valid       = 1'b0;
    req_ch.op          = OP_LOOKUP;
    req_ch.key         = '0;
    req_ch.object_size = '0;
    rsp_ch.ready       = 1'b0;
    calm = 1'b0;
    errors = 0; send_gap = 0; stall_left = 0; idle_cycles = 0;
    n_hit = 0; n_miss = 0; n_stored = 0; n_refused = 0; n_cfg = 0;
    size_limit = MAX_OBJ_RESET;
    for (int i = 0; i < NSLOTS; i++) begin
      dir_key[i]   = '0;
      dir_size[i]  = '0;
      dir_valid[i] = 1'b0;
      dir_rank[i]  = RANK_W'(NSLOTS - i);
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty miss, limit edges, duplicates, eviction order
    put(OP_LOOKUP, '0, '0);
    put(OP_INSERT, '0, '0);
    put(OP_INSERT, '1, {4'b0, MAX_OBJ_RESET});
    put(OP_INSERT, 64'h1234, {4'b0, MAX_OBJ_RESET} + 1'b1);
    put(OP_INSERT, 64'h5678, '1);
    put(OP_LOOKUP, '0, '1);
    put(OP_LOOKUP, '1, '0);
    put(OP_INSERT, '1, 24'd7);
    put(OP_LOOKUP, '1, '0);
    for (int j = 0; j < 8; j++)
      put(OP_INSERT, 64'hA5A5_0000_0000_0000 | j, OBJ_SIZE_W'(j * 1000));
    put(OP_LOOKUP, '0, '0);
    put(OP_LOOKUP, 64'hA5A5_0000_0000_0003, 24'h00F00F);
    put(OP_INSERT, 64'h5A5A_FFFF_0000_1111, 24'd100);
    drain();

    write_limit('1);
    gen_items(250);
    drain();

    write_limit('0);
    gen_items(150);
    drain();

    write_limit(SIZE_W'($urandom_range(1000, 500000)));
    gen_items(120);
    // pause the sender until every result is back
    drain();
    gen_items(130);
    drain();

    calm = 1'b1;
    write_limit(SIZE_W'($urandom_range(0, 20'hFFFFF)));
    gen_items(180);
    drain();
    repeat (10) @(posedge clk);

    $display("Checked %0d lookups (%0d hits, %0d misses) and %0d inserts (%0d stored, %0d refused)",
             n_hit + n_miss, n_hit, n_miss, n_stored + n_refused, n_stored, n_refused);
    $display("Size limit rewritten %0d times, from 0 up to 1048575, with stalls on both sides",
             n_cfg);
    if (errors == 0) begin
      $display("PASS lru_object_cache_directory_core");
    end else begin
      $display("FAIL lru_object_cache_directory_core");
    end
    $finish;
  end

endmodule
`default_nettype wire
